/* sv/irq_fiq_interrupt_controller_defines.svh */
// assertion macros used by the interrupt controller core
`ifndef IRQ_FIQ_INTERRUPT_CONTROLLER_DEFINES_SVH
`define IRQ_FIQ_INTERRUPT_CONTROLLER_DEFINES_SVH

// next cycle implication, checked on i_clk and held off during reset
`define IRQC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interrupt controller assertion failed");

// same cycle implication
`define IRQC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interrupt controller assertion failed");

`endif

/* sv/irqc_pkg.sv */
// types and constants shared by the interrupt controller modules
`timescale 1ns / 1ps

package irqc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    typedef enum logic [2:0] {
        FUNC_READ     = 3'd0,
        FUNC_WRITE    = 3'd1,
        FUNC_LINE     = 3'd2,
        FUNC_PULSE    = 3'd3,
        FUNC_HOLD_CLR = 3'd4
    } t_func;

    // word index, offset / 4; four and above is acknowledge
    localparam logic [2:0] WIDX_HOLD   = 3'd0;
    localparam logic [2:0] WIDX_STATUS = 3'd1;
    localparam logic [2:0] WIDX_ENABLE = 3'd2;
    localparam logic [2:0] WIDX_MASK   = 3'd3;

    localparam logic [1:0] LANE_TOP = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LEVEL  = 2'd0;
    localparam logic [1:0] CFG_STATUS = 2'd1;
    localparam logic [1:0] CFG_IRQ    = 2'd2;
    localparam logic [1:0] CFG_FIQ    = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] level_bits;
        logic [WORD_W-1:0] status_bits;
        logic [WORD_W-1:0] irq_bits;
        logic [WORD_W-1:0] fiq_bits;
    } t_cfg;

    typedef struct packed {
        t_func             func;
        logic [4:0]        offset;
        logic [7:0]        write_byte;
        logic [WORD_W-1:0] line_bits;
        logic              line_level;
    } t_item;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic [WORD_W-1:0] line_status;
        logic              irq_out;
        logic              fiq_out;
    } t_result;

endpackage

/* sv/irq_fiq_interrupt_controller.sv */
// interrupt controller top level: input word register, step logic, result register
//
// input channel: i_valid / o_stall with fields i_func, i_offset, i_write_byte,
// i_line_bits, i_line_level; a word is taken at a rising edge with i_valid high
// and o_stall low. output channel: o_valid / i_stall with o_read_byte,
// o_line_status, o_irq_out and o_fiq_out, one result word per input word.
// the word lands in the input register; the step logic then updates the
// interrupt words and fills the result register. throughput is one word per
// cycle while the receiver does not stall, set by the combinational step
// between the two registers. when the receiver stalls with a result waiting, both
// stages freeze and o_stall rises in the same cycle; the result register holds.
// the apb port writes level, status, irq and fiq bit sets at byte 0, 4, 8, 12;
// the user must write it only while no word is in flight; no hardware enforces it.
// synchronous active-low reset clears all interrupt words, scratch words,
// configuration and the valid flags.
`timescale 1ns / 1ps

module irq_fiq_interrupt_controller
    import irqc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_offset,
    input  logic [7:0]  i_write_byte,
    input  logic [31:0] i_line_bits,
    input  logic        i_line_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_byte,
    output logic [31:0] o_line_status,
    output logic        o_irq_out,
    output logic        o_fiq_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    adv;
    logic    r_in_valid, r_out_valid;
    t_item   r_item;
    t_result r_res, step_res;
    t_cfg    cfg;

    // pipeline moves unless a result is waiting on a stalled receiver
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_item.func       <= t_func'(i_func);
            r_item.offset     <= i_offset;
            r_item.write_byte <= i_write_byte;
            r_item.line_bits  <= i_line_bits;
            r_item.line_level <= i_line_level;
        end
        if (adv && r_in_valid) begin
            r_res <= step_res;
        end
    end

    irqc_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irqc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv && r_in_valid),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    assign o_valid       = r_out_valid;
    assign o_read_byte   = r_res.read_byte;
    assign o_line_status = r_res.line_status;
    assign o_irq_out     = r_res.irq_out;
    assign o_fiq_out     = r_res.fiq_out;

endmodule

/* sv/irqc_apb.sv */
// configuration registers behind the apb port
`timescale 1ns / 1ps

module irqc_apb
    import irqc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                CFG_LEVEL:  r_cfg.level_bits  <= pwdata;
                CFG_STATUS: r_cfg.status_bits <= pwdata;
                CFG_IRQ:    r_cfg.irq_bits    <= pwdata;
                CFG_FIQ:    r_cfg.fiq_bits    <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            CFG_LEVEL:  prdata = r_cfg.level_bits;
            CFG_STATUS: prdata = r_cfg.status_bits;
            CFG_IRQ:    prdata = r_cfg.irq_bits;
            CFG_FIQ:    prdata = r_cfg.fiq_bits;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/irqc_core.sv */
// interrupt state words, byte collection and per-word step logic
`timescale 1ns / 1ps
`include "irq_fiq_interrupt_controller_defines.svh"

module irqc_core
    import irqc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [WORD_W-1:0] r_hold, r_status, r_enable, r_mask;
    logic [WORD_W-1:0] r_en_col, r_mask_col, r_ack_col;
    logic [WORD_W-1:0] n_hold, n_status, n_enable, n_mask;
    logic [WORD_W-1:0] n_en_col, n_mask_col, n_ack_col;

    logic [2:0]        widx;
    logic [1:0]        lane;
    logic [4:0]        shamt;
    logic [WORD_W-1:0] lane_mask, lane_data, line, rd_word;
    logic [7:0]        rd_byte;

    assign widx      = i_item.offset[4:2];
    assign lane      = i_item.offset[1:0];
    assign shamt     = {lane, 3'b000};
    assign lane_mask = {24'd0, BYTE_MASK} << shamt;
    assign lane_data = {24'd0, i_item.write_byte} << shamt;
    assign line      = i_item.line_bits;

    // read mux, mask and acknowledge read back as zero
    always_comb begin
        case (widx)
            WIDX_HOLD:   rd_word = r_hold;
            WIDX_STATUS: rd_word = r_status;
            WIDX_ENABLE: rd_word = r_enable;
            default:     rd_word = '0;
        endcase
        rd_byte = 8'(rd_word >> shamt);
    end

    always_comb begin
        n_hold     = r_hold;
        n_status   = r_status;
        n_enable   = r_enable;
        n_mask     = r_mask;
        n_en_col   = r_en_col;
        n_mask_col = r_mask_col;
        n_ack_col  = r_ack_col;
        case (i_item.func)
            FUNC_WRITE: begin
                case (widx)
                    WIDX_HOLD, WIDX_STATUS: ;
                    WIDX_ENABLE: begin
                        n_en_col = (r_en_col & ~lane_mask) | lane_data;
                        if (lane == LANE_TOP) n_enable = r_enable | n_en_col;
                    end
                    WIDX_MASK: begin
                        n_mask_col = (r_mask_col & ~lane_mask) | lane_data;
                        if (lane == LANE_TOP) begin
                            n_enable = r_enable & ~n_mask_col;
                            n_mask   = n_mask_col;
                        end
                    end
                    default: begin
                        n_ack_col = (r_ack_col & ~lane_mask) | lane_data;
                        if (lane == LANE_TOP) begin
                            n_hold   = r_hold & ~n_ack_col;
                            n_status = r_status & ~(n_ack_col & ~i_cfg.level_bits);
                        end
                    end
                endcase
            end
            FUNC_LINE: begin
                if (line != '0) begin
                    if (i_item.line_level) begin
                        n_hold   = r_hold | line;
                        n_status = r_status | (line & i_cfg.status_bits);
                    end else begin
                        n_hold   = r_hold & ~line;
                        n_status = r_status & ~line;
                    end
                end
            end
            FUNC_PULSE: begin
                if (line != '0) begin
                    n_hold = r_hold | line;
                    if (i_item.line_level) n_status = r_status | (line & i_cfg.status_bits);
                    else                   n_status = r_status & ~line;
                end
            end
            FUNC_HOLD_CLR: begin
                n_hold = r_hold & ~line;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= '0;
            r_status   <= '0;
            r_enable   <= '0;
            r_mask     <= '0;
            r_en_col   <= '0;
            r_mask_col <= '0;
            r_ack_col  <= '0;
        end else if (i_step) begin
            r_hold     <= n_hold;
            r_status   <= n_status;
            r_enable   <= n_enable;
            r_mask     <= n_mask;
            r_en_col   <= n_en_col;
            r_mask_col <= n_mask_col;
            r_ack_col  <= n_ack_col;
        end
    end

    assign o_res.read_byte   = (i_item.func == FUNC_READ) ? rd_byte : 8'd0;
    assign o_res.line_status = n_status & line;
    assign o_res.irq_out     = |(n_hold & n_enable & i_cfg.irq_bits);
    assign o_res.fiq_out     = |(n_hold & n_enable & i_cfg.fiq_bits);

    // step kinds watched by the checks below
    logic step_read, step_ro_write, step_mask_top;

    assign step_read     = i_step && i_item.func == FUNC_READ;
    assign step_ro_write = i_step && i_item.func == FUNC_WRITE && widx <= WIDX_STATUS;
    assign step_mask_top = i_step && i_item.func == FUNC_WRITE && widx == WIDX_MASK
                           && lane == LANE_TOP;

    // reads never disturb the interrupt words
    `IRQC_ASSERT_NEXT(a_read_keeps_state, step_read, $stable({r_hold, r_status, r_enable, r_mask}))
    // writes to hold or status touch no scratch word
    `IRQC_ASSERT_NEXT(a_ro_write_keeps_scratch, step_ro_write, $stable({r_en_col, r_mask_col, r_ack_col}))
    // a finished mask write leaves no masked bit enabled
    `IRQC_ASSERT_NEXT(a_mask_clears_enable, step_mask_top, (r_enable & r_mask) == '0)

endmodule
